### rtl/best_fit_free_page_finder_top_defines.svh
// ----------------------------------------------------------------------------
// best-fit free page finder assertion macros
// shared property shapes for the port-level checker
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_FREE_PAGE_FINDER_TOP_DEFINES_SVH
`define BEST_FIT_FREE_PAGE_FINDER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define BFFPF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BFFPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bffpf_pkg.sv
// ----------------------------------------------------------------------------
// bffpf_pkg
// shared widths, codes and types of the best-fit free page finder
// ----------------------------------------------------------------------------
package bffpf_pkg;

  localparam int NUM_FILES_DEF      = 16;
  localparam int PAGES_PER_FILE_DEF = 256;

  localparam int FILE_W      = 4;
  localparam int PAGE_IN_W   = 8;
  localparam int SPACE_W     = 16;
  localparam int OUT_PAGE_W  = 8;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;

  // wide enough for 256 files of 4096 pages
  localparam int MAX_ADDR_W = 20;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [SPACE_W-1:0] space;
  } entry_t;

  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [MAX_ADDR_W-1:0] addr;
    entry_t                wdata;
  } mem_req_t;

  typedef struct packed {
    logic               hit;
    logic [SPACE_W-1:0] req;
    logic [SPACE_W-1:0] best_space;
  } scan_st_t;

endpackage

### rtl/best_fit_free_page_finder_top.sv
// ----------------------------------------------------------------------------
// best_fit_free_page_finder_top
// best-fit free page finder over a per-file table of page free space
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all NUM_FILES * PAGES_PER_FILE
// entries (4096 at the defaults) that marks every page entry empty; in_tready
// stays low until it ends. A set transfer (in_tuser = 0) writes one page's free
// space in the cycle it is taken and gives no result, so sets run one per
// cycle. A find transfer (in_tuser = 1) reads every page of its file in turn
// through the single-port page memory and one shared compare unit, then loads
// the result register once the previous result is no longer held back by
// out_tready; in_tready stays low until then. A find on a file at or above
// NUM_FILES skips the scan and answers not found.
// out_tuser carries the found flag; out_tdata is the page number, zero when
// nothing fits.
module best_fit_free_page_finder_top #(
  parameter int NUM_FILES      = bffpf_pkg::NUM_FILES_DEF,
  parameter int PAGES_PER_FILE = bffpf_pkg::PAGES_PER_FILE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [3:0] file_index, [11:4] page_index, [27:12] space_amount, [31:28] zero
  input  logic [bffpf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] opcode
  input  logic [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] found_page
  output logic [bffpf_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] found
  output logic [0:0]                        out_tuser
);
  import bffpf_pkg::*;

  localparam int DEPTH = NUM_FILES * PAGES_PER_FILE;
  localparam int AW    = $clog2(DEPTH);

  mem_req_t mem_req;
  entry_t   rd_data;
  scan_st_t scan_st;
  logic     take;

  bffpf_seq #(
    .NUM_FILES      (NUM_FILES),
    .PAGES_PER_FILE (PAGES_PER_FILE)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mem_req    (mem_req),
    .rd_data    (rd_data),
    .scan_st    (scan_st),
    .take       (take)
  );

  bffpf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  bffpf_cmp u_cmp (
    .ent     (rd_data),
    .scan_st (scan_st),
    .take    (take)
  );

endmodule

### rtl/bffpf_store.sv
// ----------------------------------------------------------------------------
// bffpf_store
// single-port free-space memory, one entry per page, registered read
// ----------------------------------------------------------------------------
module bffpf_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic              clk,
  input  bffpf_pkg::mem_req_t mem_req,
  output bffpf_pkg::entry_t   rd_data
);
  import bffpf_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.addr[AW-1:0]] <= mem_req.wdata;
    end
    if (mem_req.re) begin
      rd_data_r <= mem[mem_req.addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/bffpf_cmp.sv
// ----------------------------------------------------------------------------
// bffpf_cmp
// shared compare unit: decides whether a scanned entry becomes the best fit
// ----------------------------------------------------------------------------
module bffpf_cmp (
  input  bffpf_pkg::entry_t   ent,
  input  bffpf_pkg::scan_st_t scan_st,
  output logic                take
);
  import bffpf_pkg::*;

  logic fits;
  logic better;

  assign fits   = ent.valid && (ent.space >= scan_st.req);
  // strict less keeps the lowest page on a tie, pages come in ascending order
  assign better = !scan_st.hit || (ent.space < scan_st.best_space);
  assign take   = fits && better;

endmodule

### rtl/bffpf_seq.sv
// ----------------------------------------------------------------------------
// bffpf_seq
// sequencer: clearing pass, set writes, page scan and result register
// ----------------------------------------------------------------------------
module bffpf_seq #(
  parameter int NUM_FILES      = 16,
  parameter int PAGES_PER_FILE = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bffpf_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [0:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bffpf_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [0:0]                         out_tuser,
  output bffpf_pkg::mem_req_t                mem_req,
  input  bffpf_pkg::entry_t                  rd_data,
  output bffpf_pkg::scan_st_t                scan_st,
  input  logic                               take
);
  import bffpf_pkg::*;

  localparam int DEPTH = NUM_FILES * PAGES_PER_FILE;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(PAGES_PER_FILE);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]       rd_addr_r, rd_addr_nxt;
  logic [PW-1:0]       page_r, page_nxt;
  logic                cmp_v_r, cmp_v_nxt;
  logic [PW-1:0]       cmp_page_r, cmp_page_nxt;
  logic [SPACE_W-1:0]  req_r, req_nxt;
  logic                hit_r, hit_nxt;
  logic [SPACE_W-1:0]  best_space_r, best_space_nxt;
  logic [PW-1:0]       best_page_r, best_page_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [OUT_PAGE_W-1:0] out_page_r, out_page_nxt;

  logic                 in_op;
  logic [FILE_W-1:0]    in_file;
  logic [PAGE_IN_W-1:0] in_page;
  logic [SPACE_W-1:0]   in_space;
  logic                 in_fire;
  logic                 file_ok;
  logic                 page_ok;
  logic [AW-1:0]        base_addr;
  logic [AW-1:0]        set_addr;
  logic                 out_free;

  assign in_op    = in_tuser[0];
  assign in_file  = in_tdata[FILE_W-1:0];
  assign in_page  = in_tdata[FILE_W+PAGE_IN_W-1:FILE_W];
  assign in_space = in_tdata[FILE_W+PAGE_IN_W+SPACE_W-1:FILE_W+PAGE_IN_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign file_ok   = 32'(in_file) < 32'(NUM_FILES);
  assign page_ok   = 32'(in_page) < 32'(PAGES_PER_FILE);
  assign base_addr = AW'(32'(in_file) * 32'(PAGES_PER_FILE));
  assign set_addr  = AW'(32'(in_file) * 32'(PAGES_PER_FILE) + 32'(in_page));
  assign out_free  = !out_tvalid_r || out_tready;

  assign scan_st.hit        = hit_r;
  assign scan_st.req        = req_r;
  assign scan_st.best_space = best_space_r;

  always_comb begin
    mem_req = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = MAX_ADDR_W'(clr_addr_r);
      end
      ST_IDLE: begin
        if (in_fire && (in_op == OP_SET) && file_ok && page_ok) begin
          mem_req.we          = 1'b1;
          mem_req.addr        = MAX_ADDR_W'(set_addr);
          mem_req.wdata.valid = 1'b1;
          mem_req.wdata.space = in_space;
        end
      end
      ST_SCAN: begin
        mem_req.re   = 1'b1;
        mem_req.addr = MAX_ADDR_W'(rd_addr_r);
      end
      ST_DRAIN, ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    rd_addr_nxt    = rd_addr_r;
    page_nxt       = page_r;
    cmp_v_nxt      = 1'b0;
    cmp_page_nxt   = cmp_page_r;
    req_nxt        = req_r;
    hit_nxt        = hit_r;
    best_space_nxt = best_space_r;
    best_page_nxt  = best_page_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_page_nxt   = out_page_r;

    // entry read in the previous cycle is judged now
    if (cmp_v_r && take) begin
      hit_nxt        = 1'b1;
      best_space_nxt = rd_data.space;
      best_page_nxt  = cmp_page_r;
    end

    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire && (in_op == OP_FIND)) begin
          req_nxt        = in_space;
          hit_nxt        = 1'b0;
          best_space_nxt = '0;
          best_page_nxt  = '0;
          if (file_ok) begin
            rd_addr_nxt = base_addr;
            page_nxt    = '0;
            state_nxt   = ST_SCAN;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        rd_addr_nxt  = rd_addr_r + 1'b1;
        page_nxt     = page_r + 1'b1;
        cmp_v_nxt    = 1'b1;
        cmp_page_nxt = page_r;
        if (page_r == PW'(PAGES_PER_FILE - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_found_nxt  = hit_r;
          out_page_nxt   = hit_r ? OUT_PAGE_W'(best_page_r) : '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      cmp_v_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      cmp_v_r      <= cmp_v_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    page_r       <= page_nxt;
    cmp_page_r   <= cmp_page_nxt;
    req_r        <= req_nxt;
    hit_r        <= hit_nxt;
    best_space_r <= best_space_nxt;
    best_page_r  <= best_page_nxt;
    out_found_r  <= out_found_nxt;
    out_page_r   <= out_page_nxt;
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_page_r;
  assign out_tuser[0] = out_found_r;

endmodule

### rtl/bffpf_checker.sv
// ----------------------------------------------------------------------------
// bffpf_checker
// port-level assertions for the best-fit free page finder
// ----------------------------------------------------------------------------
`include "best_fit_free_page_finder_top_defines.svh"

module bffpf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [0:0]                        in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [bffpf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]                        out_tuser
);
  import bffpf_pkg::*;

  logic                 out_stall;
  logic                 out_miss;
  logic                 find_xfer;
  logic [OUT_TDATA_W:0] out_word;

  assign out_stall = out_tvalid && !out_tready;
  assign out_miss  = out_tvalid && (out_tuser[0] == 1'b0);
  assign find_xfer = in_tvalid && in_tready && (in_tuser[0] == OP_FIND);
  assign out_word  = {out_tuser, out_tdata};

  `BFFPF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_word), "held result changed")
  `BFFPF_ASSERT_SAME(a_miss_zero, clk, rst_n, out_miss, out_tdata == '0, "miss with nonzero page")
  `BFFPF_ASSERT_NEXT(a_find_busy, clk, rst_n, find_xfer, !in_tready, "ready right after a find")
  `BFFPF_ASSERT_SAME(a_clear_busy, clk, rst_n, !$past(rst_n), !in_tready, "ready while clearing")

endmodule

bind best_fit_free_page_finder_top bffpf_checker u_bffpf_checker (.*);

### verif/best_fit_free_page_finder_top_test.sv
// ----------------------------------------------------------------------------
// best_fit_free_page_finder_top_test
// Drives set and find transfers into the free page finder. A local model of
// every page's free space predicts each find answer, and the answers are
// checked in order. Both stream sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module best_fit_free_page_finder_top_test;

  import bffpf_pkg::*;

  localparam int NFILES       = NUM_FILES_DEF;
  localparam int NPAGES       = PAGES_PER_FILE_DEF;
  localparam int RANDOM_ITEMS = 900;
  localparam int STALL_LIMIT  = 20000;

  class page_fit_tracker;
    typedef struct {
      logic                  found;
      logic [OUT_PAGE_W-1:0] page;
    } answer_t;

    bit                 page_valid [NFILES*NPAGES];
    logic [SPACE_W-1:0] page_space [NFILES*NPAGES];
    answer_t            expected_answers [$];
    int                 mismatches;

    function new();
      mismatches = 0;
    endfunction

    // smallest free space that still fits, lowest page on a tie
    function answer_t best_fit(logic [FILE_W-1:0] file, logic [SPACE_W-1:0] need);
      answer_t            ans;
      logic [SPACE_W-1:0] best;
      ans.found = 1'b0;
      ans.page  = '0;
      best      = '0;
      if (file < NFILES) begin
        for (int p = 0; p < NPAGES; p++) begin
          if (page_valid[file*NPAGES+p] && page_space[file*NPAGES+p] >= need &&
              (!ans.found || page_space[file*NPAGES+p] < best)) begin
            ans.found = 1'b1;
            best      = page_space[file*NPAGES+p];
            ans.page  = p[OUT_PAGE_W-1:0];
          end
        end
      end
      return ans;
    endfunction

    function void record_transfer(logic op, logic [FILE_W-1:0] file,
                                  logic [PAGE_IN_W-1:0] page, logic [SPACE_W-1:0] amount);
      if (op == OP_SET) begin
        if (file < NFILES && page < NPAGES) begin
          page_valid[file*NPAGES+page] = 1'b1;
          page_space[file*NPAGES+page] = amount;
        end
      end else begin
        expected_answers.push_back(best_fit(file, amount));
      end
    endfunction

    function void report(string what, logic ef, logic [7:0] ep, logic af, logic [7:0] ap);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch (%s): expected found=%0b page=%0d, got found=%0b page=%0d",
                 $time, what, ef, ep, af, ap);
    endfunction

    function void check_answer(logic found, logic [OUT_PAGE_W-1:0] page);
      answer_t want;
      if (expected_answers.size() == 0) begin
        report("unexpected transfer", 1'bx, 8'hxx, found, page);
      end else begin
        want = expected_answers.pop_front();
        if (found !== want.found || page !== want.page)
          report("find answer", want.found, want.page, found, page);
      end
    endfunction

    function int unsigned pending();
      return expected_answers.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [0:0]             in_tuser   = OP_SET;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;

  page_fit_tracker tracker = new();
  bit              idle_on = 1'b1;
  int              stall_left = 0;
  int              quiet_cycles = 0;

  best_fit_free_page_finder_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver stalls in random bursts while idle_on is set
  always @(negedge clk) begin
    if (!idle_on) begin
      stall_left = 0;
      out_tready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready)
      tracker.check_answer(out_tuser[0], out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [FILE_W-1:0] file, logic [PAGE_IN_W-1:0] page,
                           logic [SPACE_W-1:0] amount);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {4'b0, amount, page, file};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.record_transfer(op, file, page, amount);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  // hold off the sender until every find has been answered
  task automatic drain_answers();
    in_tvalid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  task automatic directed_items();
    send_item(OP_FIND, 4'd0,  8'd0,   16'd0);       // empty file
    send_item(OP_SET,  4'd0,  8'd0,   16'd0);
    send_item(OP_FIND, 4'd0,  8'd0,   16'd0);
    send_item(OP_FIND, 4'd0,  8'd77,  16'd1);       // nothing fits
    send_item(OP_SET,  4'd15, 8'd255, 16'hFFFF);
    send_item(OP_FIND, 4'd15, 8'd0,   16'hFFFF);
    send_item(OP_FIND, 4'd15, 8'd0,   16'd0);
    send_item(OP_SET,  4'd15, 8'd10,  16'hFFFF);    // tie, lower page wins
    send_item(OP_FIND, 4'd15, 8'd255, 16'hFFFF);
    send_item(OP_SET,  4'd15, 8'd10,  16'd100);     // replace existing page
    send_item(OP_FIND, 4'd15, 8'd0,   16'd101);
    send_item(OP_FIND, 4'd15, 8'd0,   16'd100);
    send_item(OP_FIND, 4'd15, 8'd0,   16'd50);
    send_item(OP_SET,  4'd3,  8'd128, 16'h8000);
    send_item(OP_SET,  4'd3,  8'd127, 16'h7FFF);
    send_item(OP_FIND, 4'd3,  8'd0,   16'h7FFF);
    send_item(OP_FIND, 4'd3,  8'd0,   16'h8000);
    send_item(OP_FIND, 4'd3,  8'd0,   16'h8001);
    send_item(OP_SET,  4'd10, 8'hAA,  16'h5555);
    send_item(OP_SET,  4'd5,  8'h55,  16'hAAAA);
    send_item(OP_FIND, 4'd10, 8'h55,  16'h5555);
    send_item(OP_FIND, 4'd5,  8'hAA,  16'hAAAA);
    send_item(OP_FIND, 4'd7,  8'd0,   16'hFFFF);    // empty file, top amount
  endtask

  task automatic random_items();
    logic [FILE_W-1:0]    hot_files [4];
    logic [SPACE_W-1:0]   amount_pool [8];
    logic [FILE_W-1:0]    file;
    logic [PAGE_IN_W-1:0] page;
    logic [SPACE_W-1:0]   amount;
    logic                 op;
    foreach (hot_files[k]) hot_files[k] = FILE_W'($urandom_range(0, NFILES-1));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // every third block of 100 and the tail run without stalls
      idle_on = (i < RANDOM_ITEMS*85/100) && ((i / 100) % 3 != 2);
      if (i == RANDOM_ITEMS/2) drain_answers();
      if (i % 100 == 0) begin
        foreach (amount_pool[k]) amount_pool[k] = SPACE_W'($urandom);
      end
      file = ($urandom_range(0, 4) == 0) ? FILE_W'($urandom_range(0, NFILES-1))
                                         : hot_files[$urandom_range(0, 3)];
      page = ($urandom_range(0, 1) == 0) ? PAGE_IN_W'($urandom_range(0, 15))
                                         : PAGE_IN_W'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: amount = amount_pool[$urandom_range(0, 7)];
        4:          amount = amount_pool[$urandom_range(0, 7)] + 16'd1;
        5:          amount = '0;
        6:          amount = '1;
        default:    amount = SPACE_W'($urandom);
      endcase
      op = ($urandom_range(0, 9) < 7) ? OP_SET : OP_FIND;
      send_item(op, file, page, amount);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    directed_items();
    drain_answers();
    random_items();
    in_tvalid = 1'b0;
    idle_on   = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/bffpf_pkg.sv
rtl/bffpf_store.sv
rtl/bffpf_cmp.sv
rtl/bffpf_seq.sv
rtl/best_fit_free_page_finder_top.sv
rtl/bffpf_checker.sv
verif/best_fit_free_page_finder_top_test.sv
